@@ rtl/assert_macros.svh @@
// Assertion macros for the top level, which checks its own logic with them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define KJNF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define KJNF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/kjnf_pkg.sv @@
// Package with the item types and constants of the keyboard and joystick nibble framer.
`timescale 1ns / 1ps

package kjnf_pkg;

  localparam int unsigned NIBBLES_PER_FRAME = 32;
  localparam int unsigned STATE_NIBBLES     = 22;
  localparam int unsigned STATE_BITS        = STATE_NIBBLES * 4;
  localparam int unsigned CNT_W             = $clog2(NIBBLES_PER_FRAME);
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned CSR_RIGHT_POS = 2;
  localparam int unsigned CSR_DOWN_POS  = 7;
  localparam int unsigned RSHIFT_POS    = 52;

  typedef logic [STATE_BITS-1:0] frame_t;

  typedef struct packed {
    logic [31:0] keys_cols_0_to_3;
    logic [31:0] keys_cols_4_to_7;
    logic [7:0]  keys_col_8;
    logic        cursor_up_level;
    logic        cursor_left_level;
    logic        restore_level;
    logic        capslock_level;
    logic [4:0]  joystick_one_levels;
    logic [4:0]  joystick_two_levels;
  } in_item_t;

  typedef struct packed {
    logic [3:0] data_lines;
    logic       start_of_frame;
    logic       last_of_frame;
  } out_item_t;

  // Head of the frame queue as the serializer sees it.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_head_t;

endpackage

@@ rtl/kjnf_front.sv @@
// Front end: takes a sampled frame and assembles the active-high state word.
`timescale 1ns / 1ps

module kjnf_front
  import kjnf_pkg::*;
(
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output frame_t    q_frame_o
);

  logic [63:0] low_keys;
  logic [4:0]  joy1;
  logic [4:0]  joy2;

  always_comb begin
    low_keys = {in_item_i.keys_cols_4_to_7, in_item_i.keys_cols_0_to_3};
    // Cursor keys are shifted cursor down and cursor right on the matrix.
    if (in_item_i.cursor_up_level) begin
      low_keys[CSR_DOWN_POS] = 1'b1;
      low_keys[RSHIFT_POS]   = 1'b1;
    end
    if (in_item_i.cursor_left_level) begin
      low_keys[CSR_RIGHT_POS] = 1'b1;
      low_keys[RSHIFT_POS]    = 1'b1;
    end
    joy1 = ~in_item_i.joystick_one_levels;
    joy2 = ~in_item_i.joystick_two_levels;
    q_frame_o = {3'b000, joy2[4], joy2[3:0],
                 ~in_item_i.restore_level, ~in_item_i.capslock_level, 1'b0, joy1[4],
                 joy1[3:0], in_item_i.keys_col_8, low_keys};
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

@@ rtl/kjnf_queue.sv @@
// Two-entry frame queue between the front end and the serializer.
`timescale 1ns / 1ps

module kjnf_queue
  import kjnf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  frame_t  frame_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  frame_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  assign full_o       = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.frame = mem_q[rd_ptr_q];

endmodule

@@ rtl/kjnf_back.sv @@
// Serializer: shifts a queued frame out one inverted nibble per transfer.
`timescale 1ns / 1ps

module kjnf_back
  import kjnf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_head_t   head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  frame_t           frame_q, frame_d;
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;
  logic             advance;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !busy_q && head_i.valid;

  always_comb begin
    frame_d     = frame_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (advance) begin
      if (busy_q) begin
        // The frame drains toward bit zero, so nibbles past the state are zero and go out as all ones.
        out_valid_d               = 1'b1;
        out_item_d.data_lines     = ~frame_q[3:0];
        out_item_d.start_of_frame = 1'b0;
        out_item_d.last_of_frame  = (idx_q == CNT_W'(NIBBLES_PER_FRAME - 1));
        frame_d                   = {4'b0000, frame_q[STATE_BITS-1:4]};
        idx_d                     = idx_q + 1'b1;
        if (idx_q == CNT_W'(NIBBLES_PER_FRAME - 1)) begin
          busy_d = 1'b0;
        end
      end else if (head_i.valid) begin
        out_valid_d               = 1'b1;
        out_item_d.data_lines     = ~head_i.frame[3:0];
        out_item_d.start_of_frame = 1'b1;
        out_item_d.last_of_frame  = 1'b0;
        frame_d                   = {4'b0000, head_i.frame[STATE_BITS-1:4]};
        idx_d                     = CNT_W'(1);
        busy_d                    = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/keyboard_joystick_nibble_framer_top.sv @@
// Top level of the keyboard and joystick nibble framer: front end, frame queue, serializer.
// A frame taken while idle goes into the queue, then into the serializer's output register
// as its first nibble. Frames of NIBBLES_PER_FRAME nibbles go out one a cycle from the
// shift register while not stalled; the two-entry queue keeps frames flowing with no gap.
// Reset clears the queue pointers, the serializer state and the output valid at once.
// No payload register is reset and no clearing pass runs.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module keyboard_joystick_nibble_framer_top
  import kjnf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  frame_t  q_frame;
  q_head_t q_head;
  logic    in_fire;
  logic    out_last;
  logic    out_restart;

  kjnf_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_frame_o  (q_frame)
  );

  kjnf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .frame_i (q_frame),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  kjnf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_last    = out_valid_o && !out_stall_i && out_item_o.last_of_frame;
  assign out_restart = !out_valid_o || out_item_o.start_of_frame;

  `KJNF_ASSERT(a_pop_needs_entry, q_pop |-> q_head.valid, "pop from an empty queue")
  `KJNF_ASSERT(a_accept_fills_queue, in_fire |=> q_head.valid, "accepted frame not queued")
  `KJNF_ASSERT(a_new_frame_after_last, out_last |=> out_restart, "no restart at nibble zero")
  `KJNF_ASSERT_NEVER(a_start_and_last, out_valid_o && out_item_o.start_of_frame && out_item_o.last_of_frame, "start and last on one nibble")

endmodule

@@ test/tb_keyboard_joystick_nibble_framer_top.sv @@
// Self-checking testbench for the keyboard and joystick nibble framer.
`timescale 1ns / 1ps

module tb_keyboard_joystick_nibble_framer_top;
  import kjnf_pkg::*;

  localparam int unsigned RANDOM_FRAMES   = 340;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned DRAIN_CYCLES    = NIBBLES_PER_FRAME + 8;
  localparam int unsigned IDLE_PERCENT    = 11;

  typedef struct {
    in_item_t     frame;
    bit           typed;
    logic [127:0] lines;
  } frame_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Shared pacing controls, written with nonblocking assignments by the sender.
  logic quiet    = 1'b0;
  logic hold_req = 1'b0;

  out_item_t   pending_nibbles[$];
  frame_row_t  dir_rows[$];
  int unsigned frames_sent     = 0;
  int unsigned nibbles_checked = 0;
  int unsigned mismatch_count  = 0;

  keyboard_joystick_nibble_framer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Builds the inverted 128-bit keyboard state that the data lines carry, nibble n at 4n.
  function automatic logic [127:0] frame_lines(input in_item_t f);
    logic [63:0]  keys;
    logic [4:0]   joy_one;
    logic [4:0]   joy_two;
    logic [127:0] kstate;
    keys = {f.keys_cols_4_to_7, f.keys_cols_0_to_3};
    if (f.cursor_up_level) begin
      keys[CSR_DOWN_POS] = 1'b1;
      keys[RSHIFT_POS]   = 1'b1;
    end
    if (f.cursor_left_level) begin
      keys[CSR_RIGHT_POS] = 1'b1;
      keys[RSHIFT_POS]    = 1'b1;
    end
    joy_one = ~f.joystick_one_levels;
    joy_two = ~f.joystick_two_levels;
    kstate          = '0;
    kstate[63:0]    = keys;
    kstate[71:64]   = f.keys_col_8;
    kstate[75:72]   = joy_one[3:0];
    kstate[79:76]   = {~f.restore_level, ~f.capslock_level, 1'b0, joy_one[4]};
    kstate[83:80]   = joy_two[3:0];
    kstate[87:84]   = {3'b000, joy_two[4]};
    return ~kstate;
  endfunction

  function automatic in_item_t mk_frame(input logic [31:0] cols_lo, input logic [31:0] cols_hi,
                                        input logic [7:0] col8, input logic up,
                                        input logic left, input logic restore_n,
                                        input logic caps_n, input logic [4:0] joy_one_n,
                                        input logic [4:0] joy_two_n);
    in_item_t f;
    f.keys_cols_0_to_3    = cols_lo;
    f.keys_cols_4_to_7    = cols_hi;
    f.keys_col_8          = col8;
    f.cursor_up_level     = up;
    f.cursor_left_level   = left;
    f.restore_level       = restore_n;
    f.capslock_level      = caps_n;
    f.joystick_one_levels = joy_one_n;
    f.joystick_two_levels = joy_two_n;
    return f;
  endfunction

  function automatic void add_row(input in_item_t f, input bit typed, input logic [127:0] lines);
    frame_row_t row;
    row.frame = f;
    row.typed = typed;
    row.lines = lines;
    dir_rows.push_back(row);
  endfunction

  task automatic queue_frame_nibbles(input logic [127:0] lines);
    out_item_t nib;
    for (int i = 0; i < NIBBLES_PER_FRAME; i++) begin
      // Nibbles past the assembled state carry a zero state, so the lines read all ones.
      nib.data_lines     = (i < 32) ? lines[4*i +: 4] : 4'hF;
      nib.start_of_frame = (i == 0);
      nib.last_of_frame  = (i == NIBBLES_PER_FRAME - 1);
      pending_nibbles.push_back(nib);
    end
  endtask

  task automatic send_frame(input in_item_t f, input bit typed, input logic [127:0] lines);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_frame_nibbles(typed ? lines : frame_lines(f));
    frames_sent++;
  endtask

  initial begin : stimulus
    logic [71:0] keys;
    in_item_t    f;
    int unsigned mode;

    add_row(mk_frame('0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, 5'h1F, 5'h1F), 1'b1, '1);
    add_row(mk_frame('1, '1, '1, 1'b1, 1'b1, 1'b0, 1'b0, 5'h00, 5'h00), 1'b1,
            128'hFFFF_FFFF_FFE0_2000_0000_0000_0000_0000);
    // Cursor up alone sets cursor down and right shift.
    add_row(mk_frame('0, '0, '0, 1'b1, 1'b0, 1'b1, 1'b1, 5'h1F, 5'h1F), 1'b1,
            128'hFFFF_FFFF_FFFF_FFFF_FFEF_FFFF_FFFF_FF7F);
    add_row(mk_frame('0, '0, '0, 1'b0, 1'b1, 1'b1, 1'b1, 5'h1F, 5'h1F), 1'b0, '0);
    add_row(mk_frame('0, '0, '0, 1'b1, 1'b1, 1'b1, 1'b1, 5'h1F, 5'h1F), 1'b0, '0);
    add_row(mk_frame(32'h0000_0084, 32'h0010_0000, '0, 1'b1, 1'b1, 1'b1, 1'b1, 5'h1F, 5'h1F),
            1'b0, '0);
    add_row(mk_frame('1, '1, '1, 1'b0, 1'b0, 1'b1, 1'b1, 5'h1F, 5'h1F), 1'b0, '0);
    add_row(mk_frame(32'h5555_5555, 32'hAAAA_AAAA, 8'h5A, 1'b0, 1'b0, 1'b1, 1'b0, 5'h15, 5'h0A),
            1'b0, '0);
    add_row(mk_frame(32'hAAAA_AAAA, 32'h5555_5555, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b1, 5'h0A, 5'h15),
            1'b0, '0);
    add_row(mk_frame('0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1, 5'h1F, 5'h1F), 1'b0, '0);
    add_row(mk_frame('0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b0, 5'h1F, 5'h1F), 1'b0, '0);
    for (int k = 0; k < 5; k++) begin
      add_row(mk_frame('0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, 5'h1F ^ (5'd1 << k), 5'h1F),
              1'b0, '0);
      add_row(mk_frame('0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, 5'h1F, 5'h1F ^ (5'd1 << k)),
              1'b0, '0);
    end
    add_row(mk_frame('0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1, 5'h00, 5'h00), 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].lines);

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n == 40) hold_req <= 1'b1;
      if (n == 150) quiet <= 1'b1;
      if (n == 230) quiet <= 1'b0;
      if (n == 260) begin
        // Let the block run completely dry before the next transfer.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_nibbles.size() != 0) @(posedge clk_i);
      end
      mode = $urandom_range(3);
      case (mode)
        0: begin
          keys = '0;
        end
        1: begin
          keys = '0;
          repeat ($urandom_range(1, 4)) keys[$urandom_range(71)] = 1'b1;
        end
        default: begin
          keys = {8'($urandom_range(255)), $urandom(), $urandom()};
        end
      endcase
      f = mk_frame(keys[31:0], keys[63:32], keys[71:64],
                   $urandom_range(3) == 0, $urandom_range(3) == 0,
                   $urandom_range(3) != 0, $urandom_range(3) != 0,
                   $urandom_range(1) ? 5'h1F : 5'($urandom_range(31)),
                   $urandom_range(1) ? 5'h1F : 5'($urandom_range(31)));
      send_frame(f, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_nibbles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d frames (%0d directed, %0d random) and checked %0d nibbles,",
             frames_sent, dir_rows.size(), RANDOM_FRAMES, nibbles_checked);
    $display("including a long output hold-off, a full drain and random gaps on both sides.");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, and no stalls while quiet.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1'b1;
      end else begin
        out_stall_i <= rst_ni && !quiet && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_nibbles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected nibble transfer: lines %h sof %b lof %b",
                   out_item_o.data_lines, out_item_o.start_of_frame, out_item_o.last_of_frame);
      end else begin
        want = pending_nibbles.pop_front();
        nibbles_checked++;
        if (out_item_o.data_lines !== want.data_lines ||
            out_item_o.start_of_frame !== want.start_of_frame ||
            out_item_o.last_of_frame !== want.last_of_frame) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Nibble %0d mismatch: expected lines %h sof %b lof %b, got %h %b %b",
                     nibbles_checked - 1, want.data_lines, want.start_of_frame,
                     want.last_of_frame, out_item_o.data_lines, out_item_o.start_of_frame,
                     out_item_o.last_of_frame);
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
